// ----- sv/ial_pkg.sv -----
// ial_pkg: sizes, codes and controller/datapath interface types for indexed_array_list.
// No dependencies; used by ial_ctrl, ial_datapath and indexed_array_list.
package ial_pkg;

    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;

    localparam int MODE_W  = 3;
    localparam int POS_W   = 4;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 5;

    localparam int IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int STORE_W = (DATA_WIDTH < WORD_W) ? DATA_WIDTH : WORD_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_GET    = 3'd0,
        MODE_SET    = 3'd1,
        MODE_APPEND = 3'd2,
        MODE_INSERT = 3'd3,
        MODE_REMOVE = 3'd4
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE   = 2'd0,
        ST_BOUNDS = 2'd1,
        ST_FULL   = 2'd2
    } stat_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_GET_CAP,
        S_INS,
        S_INS_LAST,
        S_REM_CAP,
        S_REM,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        RD_NONE,
        RD_POS,
        RD_CNT_M1,
        RD_PTR_DEC,
        RD_PTR_INC
    } rd_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_POS_WORD,
        WR_CNT_WORD,
        WR_PTR_INC_DATA,
        WR_PTR_DEC_DATA
    } wr_op_t;

    typedef struct packed {
        logic   load;
        logic   latch_stat;
        rd_op_t rd_op;
        wr_op_t wr_op;
        logic   cap_data;
        logic   cnt_inc;
        logic   cnt_dec;
        logic   out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        mode_t mode;
        stat_t stat;
        logic  ins_last;
        logic  rem_last;
        logic  out_busy;
    } dp_sts_t;

endpackage

// ----- sv/ial_ctrl.sv -----
// ial_ctrl: sequencing state machine for indexed_array_list.
// Depends on ial_pkg; drives ial_datapath through ctrl_cmd_t, reads dp_sts_t.
module ial_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ial_pkg::dp_sts_t    sts,
    output ial_pkg::ctrl_cmd_t  cmd
);

    ial_pkg::state_t state_reg;
    ial_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ial_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ial_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ial_pkg::S_DECODE;
                end
            end
            ial_pkg::S_DECODE:
            begin
                if (sts.stat != ial_pkg::ST_DONE)
                begin
                    state_next = ial_pkg::S_DONE;
                end
                else
                begin
                    unique case (sts.mode)
                        ial_pkg::MODE_GET:    state_next = ial_pkg::S_GET_CAP;
                        ial_pkg::MODE_INSERT: state_next = ial_pkg::S_INS;
                        ial_pkg::MODE_REMOVE: state_next = ial_pkg::S_REM_CAP;
                        default:              state_next = ial_pkg::S_DONE;
                    endcase
                end
            end
            ial_pkg::S_GET_CAP:  state_next = ial_pkg::S_DONE;
            ial_pkg::S_INS:
            begin
                if (sts.ins_last)
                begin
                    state_next = ial_pkg::S_INS_LAST;
                end
            end
            ial_pkg::S_INS_LAST: state_next = ial_pkg::S_DONE;
            ial_pkg::S_REM_CAP:
            begin
                state_next = sts.rem_last ? ial_pkg::S_DONE : ial_pkg::S_REM;
            end
            ial_pkg::S_REM:
            begin
                if (sts.rem_last)
                begin
                    state_next = ial_pkg::S_DONE;
                end
            end
            ial_pkg::S_DONE:
            begin
                if (!sts.out_busy)
                begin
                    state_next = ial_pkg::S_IDLE;
                end
            end
            default:             state_next = ial_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd       = '0;
        cmd.rd_op = ial_pkg::RD_NONE;
        cmd.wr_op = ial_pkg::WR_NONE;
        in_ready  = 1'b0;
        unique case (state_reg)
            ial_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ial_pkg::S_DECODE:
            begin
                cmd.latch_stat = 1'b1;
                if (sts.stat == ial_pkg::ST_DONE)
                begin
                    unique case (sts.mode)
                        ial_pkg::MODE_GET:    cmd.rd_op = ial_pkg::RD_POS;
                        ial_pkg::MODE_SET:    cmd.wr_op = ial_pkg::WR_POS_WORD;
                        ial_pkg::MODE_APPEND:
                        begin
                            cmd.wr_op   = ial_pkg::WR_CNT_WORD;
                            cmd.cnt_inc = 1'b1;
                        end
                        ial_pkg::MODE_INSERT: cmd.rd_op = ial_pkg::RD_CNT_M1;
                        ial_pkg::MODE_REMOVE: cmd.rd_op = ial_pkg::RD_POS;
                        default:              cmd.rd_op = ial_pkg::RD_NONE;
                    endcase
                end
            end
            ial_pkg::S_GET_CAP:
            begin
                cmd.cap_data = 1'b1;
            end
            ial_pkg::S_INS:
            begin
                cmd.wr_op = ial_pkg::WR_PTR_INC_DATA;
                if (!sts.ins_last)
                begin
                    cmd.rd_op = ial_pkg::RD_PTR_DEC;
                end
            end
            ial_pkg::S_INS_LAST:
            begin
                cmd.wr_op   = ial_pkg::WR_POS_WORD;
                cmd.cnt_inc = 1'b1;
            end
            ial_pkg::S_REM_CAP:
            begin
                cmd.cap_data = 1'b1;
                if (sts.rem_last)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_op = ial_pkg::RD_PTR_INC;
                end
            end
            ial_pkg::S_REM:
            begin
                cmd.wr_op = ial_pkg::WR_PTR_DEC_DATA;
                if (sts.rem_last)
                begin
                    cmd.cnt_dec = 1'b1;
                end
                else
                begin
                    cmd.rd_op = ial_pkg::RD_PTR_INC;
                end
            end
            ial_pkg::S_DONE:
            begin
                cmd.out_load = !sts.out_busy;
            end
            default:
            begin
                cmd.load = 1'b0;
            end
        endcase
    end

endmodule

// ----- sv/ial_datapath.sv -----
// ial_datapath: entry memory, length counter, request and result registers.
// Depends on ial_pkg; controlled by ial_ctrl through ctrl_cmd_t.
module ial_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ial_pkg::ctrl_cmd_t            cmd,
    output ial_pkg::dp_sts_t              sts,
    input  logic [ial_pkg::MODE_W-1:0]    mode,
    input  logic [ial_pkg::POS_W-1:0]     position,
    input  logic [ial_pkg::WORD_W-1:0]    data_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ial_pkg::WORD_W-1:0]    data_out,
    output logic [ial_pkg::STAT_W-1:0]    status,
    output logic [ial_pkg::LEN_W-1:0]     length
);

    logic [ial_pkg::STORE_W-1:0] mem_array [ial_pkg::CAPACITY];

    logic [ial_pkg::MODE_W-1:0]  mode_reg;
    logic [ial_pkg::POS_W-1:0]   pos_reg;
    logic [ial_pkg::STORE_W-1:0] word_reg;
    logic [ial_pkg::CNT_W-1:0]   count_reg;
    logic [ial_pkg::CNT_W-1:0]   count_next;
    logic [ial_pkg::IDX_W-1:0]   ptr_reg;
    logic [ial_pkg::IDX_W-1:0]   ptr_next;
    logic [ial_pkg::STORE_W-1:0] rdata_reg;
    logic [ial_pkg::STORE_W-1:0] hold_reg;
    ial_pkg::stat_t              stat_reg;
    logic                        out_valid_reg;
    logic                        out_valid_next;
    logic [ial_pkg::WORD_W-1:0]  data_out_reg;
    logic [ial_pkg::STAT_W-1:0]  status_reg;
    logic [ial_pkg::LEN_W-1:0]   length_reg;

    logic [ial_pkg::CMP_W-1:0]   pos_cmp;
    logic [ial_pkg::CMP_W-1:0]   cnt_cmp;
    logic [ial_pkg::CNT_W-1:0]   cnt_m1;
    logic [ial_pkg::IDX_W-1:0]   pos_idx;
    logic                        bounds;
    logic                        full;
    ial_pkg::stat_t              stat_now;
    logic                        rd_en;
    logic [ial_pkg::IDX_W-1:0]   rd_addr;
    logic                        wr_en;
    logic [ial_pkg::IDX_W-1:0]   wr_addr;
    logic [ial_pkg::STORE_W-1:0] wr_data;

    assign pos_cmp = ial_pkg::CMP_W'(pos_reg);
    assign cnt_cmp = ial_pkg::CMP_W'(count_reg);
    assign cnt_m1  = count_reg - ial_pkg::CNT_W'(1);
    assign pos_idx = pos_cmp[ial_pkg::IDX_W-1:0];
    assign bounds  = (pos_cmp >= cnt_cmp);
    assign full    = (count_reg >= ial_pkg::CNT_W'(ial_pkg::CAPACITY));

    always_comb
    begin
        unique case (ial_pkg::mode_t'(mode_reg))
            ial_pkg::MODE_GET,
            ial_pkg::MODE_SET,
            ial_pkg::MODE_REMOVE: stat_now = bounds ? ial_pkg::ST_BOUNDS : ial_pkg::ST_DONE;
            ial_pkg::MODE_APPEND: stat_now = full ? ial_pkg::ST_FULL : ial_pkg::ST_DONE;
            ial_pkg::MODE_INSERT:
            begin
                priority if (bounds)
                begin
                    stat_now = ial_pkg::ST_BOUNDS;
                end
                else if (full)
                begin
                    stat_now = ial_pkg::ST_FULL;
                end
                else
                begin
                    stat_now = ial_pkg::ST_DONE;
                end
            end
            default:              stat_now = ial_pkg::ST_BOUNDS;
        endcase
    end

    // read port; ptr tracks the last address read
    always_comb
    begin
        rd_en    = 1'b1;
        rd_addr  = ptr_reg;
        ptr_next = ptr_reg;
        unique case (cmd.rd_op)
            ial_pkg::RD_POS:     rd_addr = pos_idx;
            ial_pkg::RD_CNT_M1:  rd_addr = cnt_m1[ial_pkg::IDX_W-1:0];
            ial_pkg::RD_PTR_DEC: rd_addr = ptr_reg - ial_pkg::IDX_W'(1);
            ial_pkg::RD_PTR_INC: rd_addr = ptr_reg + ial_pkg::IDX_W'(1);
            default:             rd_en   = 1'b0;
        endcase
        if (rd_en)
        begin
            ptr_next = rd_addr;
        end
    end

    always_comb
    begin
        wr_en   = 1'b1;
        wr_addr = pos_idx;
        wr_data = word_reg;
        unique case (cmd.wr_op)
            ial_pkg::WR_POS_WORD: wr_addr = pos_idx;
            ial_pkg::WR_CNT_WORD: wr_addr = count_reg[ial_pkg::IDX_W-1:0];
            ial_pkg::WR_PTR_INC_DATA:
            begin
                wr_addr = ptr_reg + ial_pkg::IDX_W'(1);
                wr_data = rdata_reg;
            end
            ial_pkg::WR_PTR_DEC_DATA:
            begin
                wr_addr = ptr_reg - ial_pkg::IDX_W'(1);
                wr_data = rdata_reg;
            end
            default:              wr_en = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem_array[rd_addr];
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + ial_pkg::CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - ial_pkg::CNT_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        if (cmd.load)
        begin
            mode_reg <= mode;
            pos_reg  <= position;
            word_reg <= data_in[ial_pkg::STORE_W-1:0];
            hold_reg <= '0;
        end
        else if (cmd.cap_data)
        begin
            hold_reg <= rdata_reg;
        end
        if (cmd.latch_stat)
        begin
            stat_reg <= stat_now;
        end
        if (cmd.out_load)
        begin
            data_out_reg <= ial_pkg::WORD_W'(hold_reg);
            status_reg   <= stat_reg;
            length_reg   <= ial_pkg::LEN_W'(count_reg);
        end
    end

    assign sts.mode     = ial_pkg::mode_t'(mode_reg);
    assign sts.stat     = stat_now;
    assign sts.ins_last = (ptr_reg == pos_idx);
    assign sts.rem_last = ((ial_pkg::CNT_W'(ptr_reg) + ial_pkg::CNT_W'(1)) == count_reg);
    assign sts.out_busy = out_valid_reg && !out_ready;

    assign out_valid = out_valid_reg;
    assign data_out  = data_out_reg;
    assign status    = status_reg;
    assign length    = length_reg;

endmodule

// ----- sv/indexed_array_list.sv -----
// indexed_array_list: top level, controller plus datapath.
// Depends on ial_pkg, ial_ctrl, ial_datapath.
//
// Usage: requests enter on in_valid/in_ready with mode, position, data_in;
// one result word per request leaves on out_valid/out_ready with data_out,
// status and length. Modes: get, set, append, insert, remove.
// One request is worked at a time; in_ready is high only when idle.
// Set, append and rejected requests go straight to the result; get reads
// the entry first; insert and remove shift the entries between position
// and the end through the entry memory (one read and one write port, one
// move per cycle), so they take longer the nearer position is to the front.
// The result sits in an output register; the next request may be accepted
// while it waits. If the receiver stalls, the following result waits in
// the controller until the output register frees up.
// Reset (rst_n low, asynchronous) empties the list and drops any result;
// entry contents are not cleared and are only read after being written.
module indexed_array_list (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ial_pkg::MODE_W-1:0]    mode,
    input  logic [ial_pkg::POS_W-1:0]     position,
    input  logic [ial_pkg::WORD_W-1:0]    data_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ial_pkg::WORD_W-1:0]    data_out,
    output logic [ial_pkg::STAT_W-1:0]    status,
    output logic [ial_pkg::LEN_W-1:0]     length
);

    ial_pkg::ctrl_cmd_t cmd;
    ial_pkg::dp_sts_t   sts;

    ial_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ial_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .mode      (mode),
        .position  (position),
        .data_in   (data_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data_out  (data_out),
        .status    (status),
        .length    (length)
    );

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a word while a request was in flight");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result load did not raise out_valid");

    a_full_length: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == ial_pkg::ST_FULL) |-> length == ial_pkg::LEN_W'(ial_pkg::CAPACITY))
        else $error("full status with list not at capacity");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ial_pkg::ST_DONE) |-> data_out == '0)
        else $error("rejected request returned nonzero data");
`endif

endmodule
